### src/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types, constants and the long division step for difficulty_to_target.
// ----------------------------------------------------------------------------
package dtt_pkg;

   localparam int DIV_W     = 53;
   localparam int REM_W     = DIV_W + 1;
   localparam int QUO_W     = 256;
   localparam int WORD_W    = 64;
   localparam int PROD_W    = 52;
   localparam int NUM_CELLS = 64;
   localparam int STEPS     = 4;

   localparam logic [19:0] SCALE = 20'd1000000;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(64'h8000_0000);

   // 0xffff * 10^6 * 2^208, the dividend of every division.
   localparam logic [QUO_W-1:0] NUMER = (256'd65535 * 256'd1000000) << 208;

   localparam logic [1:0] PH_HAND = 2'd3;

   localparam int ST_STATUS = 0;
   localparam int ST_SAT    = 1;

   typedef struct packed {
      logic             valid;
      logic             err;
      logic [DIV_W-1:0] div;
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } cell_type;

   function automatic cell_type cell_step(cell_type c, logic nb);
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] df;
      cell_type         r;
      r  = c;
      sh = {c.rem, nb};
      df = sh - {1'b0, c.div};
      if (sh >= {1'b0, c.div}) begin
         r.rem = df[DIV_W-1:0];
         r.quo = {c.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.rem = sh[DIV_W-1:0];
         r.quo = {c.quo[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

### src/dtt_cell.sv
// ----------------------------------------------------------------------------
// dtt_cell
// One cell of the divider chain: four quotient bits, one per cycle while the chain is not stalled at hand-over.
// ----------------------------------------------------------------------------
module dtt_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        phase,
   input  logic              adv,
   input  dtt_pkg::cell_type prev_in,
   output dtt_pkg::cell_type step_out
);
   import dtt_pkg::*;

   localparam int BASE = QUO_W - 1 - STEPS * CELL_IDX;
   localparam logic [STEPS-1:0] NB = NUMER[BASE -: STEPS];

   cell_type cur_ff;
   cell_type cur_in;

   assign step_out = cell_step(cur_ff, NB[~phase]);

   always_comb begin
      cur_in = cur_ff;
      if (adv) begin
         cur_in = prev_in;
      end else if (phase != PH_HAND) begin
         cur_in = step_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

endmodule

### src/dtt_out.sv
// ----------------------------------------------------------------------------
// dtt_out
// Result buffer that sends the target as four words, or one error word.
// ----------------------------------------------------------------------------
module dtt_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  dtt_pkg::cell_type data_in,
   output logic              free,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,  // target_word, word_index, zero padding
   output logic              rsp_tlast,
   output logic [1:0]        rsp_tuser   // status, saturated
);
   import dtt_pkg::*;

   logic             valid_ff, valid_in;
   logic             err_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [1:0]       idx_ff, idx_in;
   logic [WORD_W-1:0] word;
   logic             xfer;

   assign xfer = rsp_tvalid && rsp_tready;
   assign free = !valid_ff || (rsp_tready && rsp_tlast);
   assign word = err_ff ? '0 : quo_ff[QUO_W - 1 - WORD_W * idx_ff -: WORD_W];

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = err_ff || (idx_ff == 2'd3);
   assign rsp_tdata  = {6'd0, idx_ff, word};
   assign rsp_tuser  = {1'b0, err_ff};

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (xfer) begin
         if (rsp_tlast) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff <= data_in.err;
         quo_ff <= data_in.quo;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[ST_STATUS]) |-> (rsp_tlast && idx_ff == 2'd0))
      else $error("error result is not a single word");

endmodule

### src/difficulty_to_target.sv
// ----------------------------------------------------------------------------
// difficulty_to_target
// The chain takes a new input only in the hand-over phase of its cells, and
// only while the result buffer can take the last cell's result; many inputs
// are in the chain at once. A result leaves as four words or one error word.
// Synchronous reset empties the chain and the result buffer at once.
// ----------------------------------------------------------------------------
module difficulty_to_target (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // difficulty_fx
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // target_word, word_index, zero padding
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // status, saturated
);
   import dtt_pkg::*;

   logic [1:0]        phase_ff, phase_in;
   logic              adv;
   logic              ob_free;
   logic              fr_valid_ff;
   logic [PROD_W-1:0] hp_ff, lp_ff;
   logic [DIV_W-1:0]  s_val;
   cell_type          init;
   cell_type          nxt [NUM_CELLS];

   assign adv        = (phase_ff == PH_HAND) && !(nxt[NUM_CELLS-1].valid && !ob_free);
   assign req_tready = adv;
   assign phase_in   = (phase_ff != PH_HAND || adv) ? phase_ff + 2'd1 : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= 2'd0;
         fr_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (adv) begin
            fr_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hp_ff <= PROD_W'(req_tdata[63:32]) * PROD_W'(SCALE);
         lp_ff <= PROD_W'(req_tdata[31:0]) * PROD_W'(SCALE) + HALF;
      end
   end

   assign s_val = DIV_W'(hp_ff) + DIV_W'(lp_ff[PROD_W-1:32]);

   always_comb begin
      init       = '0;
      init.valid = fr_valid_ff;
      init.div   = s_val;
      init.err   = (s_val == '0);
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      dtt_cell #(.CELL_IDX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .phase    (phase_ff),
         .adv      (adv),
         .prev_in  ((i == 0) ? init : nxt[(i == 0) ? 0 : i - 1]),
         .step_out (nxt[i])
      );
   end

   dtt_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (adv && nxt[NUM_CELLS-1].valid),
      .data_in    (nxt[NUM_CELLS-1]),
      .free       (ob_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (phase_ff == PH_HAND))
      else $error("input taken outside the hand-over cycle");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HAND && !adv) |=> (phase_ff == PH_HAND))
      else $error("chain moved while the result buffer was full");

   assert property (@(posedge clock) disable iff (reset)
      (adv && nxt[NUM_CELLS-1].valid) |-> ob_free)
      else $error("result buffer overwritten");

endmodule
